### hdl/mdf_pkg.sv
// ----------------------------------------------------------------------------
// Message deframer package
// Shared widths, register indexes, mode codes and the queue entry type.
// ----------------------------------------------------------------------------
package mdf_pkg;

  localparam int BYTE_W       = 8;
  localparam int REG_W        = 32;
  localparam int CFG_IDX_W    = 1;
  localparam int MODE_W       = 2;

  // Length header and length arithmetic.
  localparam int PREFIX_BYTES = 4;
  localparam int PC_W         = 2;
  localparam int ACC_W        = 8 * PREFIX_BYTES;
  localparam int LEN_W        = 32;

  // Header field that carries the body length.
  localparam int NAME_LEN     = 16;
  localparam int IDX_W        = $clog2(NAME_LEN);
  localparam logic [8*NAME_LEN-1:0] FIELD_NAME = "Content-Length: ";

  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_0  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_9  = 8'h39;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 1'd1;

  // Framing modes; the unused code behaves as raw passthrough.
  localparam logic [MODE_W-1:0] MODE_RAW    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PREFIX = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HTTP   = 2'd2;

  localparam logic [REG_W-1:0] MAX_LENGTH_RESET = 32'd65536;

  // Queue between the classifier and the parser.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [MODE_W-1:0] frame_mode;
    logic [REG_W-1:0]  max_length;
  } cfg_t;

  // A received byte together with its character classes.
  typedef struct packed {
    logic [BYTE_W-1:0]   rx_byte;
    logic                burst_end;
    logic                is_cr;
    logic                is_lf;
    logic                is_digit;
    logic [3:0]          digit;
    logic [NAME_LEN-1:0] name_hit;
  } entry_t;

  typedef struct packed {
    logic [BYTE_W-1:0] msg_byte;
    logic              msg_last;
    logic              empty_message;
    logic              length_error;
    logic              is_body;
  } result_t;

  function automatic logic [BYTE_W-1:0] name_char(input int i);
    return FIELD_NAME[8*(NAME_LEN-1-i) +: 8];
  endfunction

endpackage

### hdl/mdf_if.sv
// ----------------------------------------------------------------------------
// Message deframer channels
// Valid/ready interfaces for received bytes and for message results.
// ----------------------------------------------------------------------------
interface mdf_in_if;
  import mdf_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              burst_end;

  modport source (output valid, output rx_byte, output burst_end, input ready);
  modport sink   (input valid, input rx_byte, input burst_end, output ready);
endinterface

interface mdf_out_if;
  import mdf_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] msg_byte;
  logic              msg_last;
  logic              empty_message;
  logic              length_error;
  logic              is_body;

  modport source (output valid, output msg_byte, output msg_last, output empty_message,
                  output length_error, output is_body, input ready);
  modport sink   (input valid, input msg_byte, input msg_last, input empty_message,
                  input length_error, input is_body, output ready);
endinterface

### hdl/message_deframer_unit.sv
// ----------------------------------------------------------------------------
// Message deframer
// Marks message boundaries in a received byte stream in one of three modes.
// ----------------------------------------------------------------------------
// Received bytes enter on the rx channel, one transaction per byte with its
// burst_end flag. Message results leave on the tx channel, at most one per
// byte: a message byte, or a marker for an empty message or a length error.
// Mode 0 passes bytes straight through, mode 1 frames by a four-byte
// little-endian length prefix, mode 2 by the HTTP header delimiter plus the
// Content-Length body. Output is cut-through: bytes appear as they arrive.
//
// Throughput is one byte per cycle in every mode while tx.ready does not
// hold the output; the parser takes one queued byte per cycle, a single
// state update with one length add and compare. An rx transaction reaches
// tx through the four-entry queue and then the output register.
//
// Reset clears the queue, the parsing state and the output valid flag, and
// sets frame_mode to 0 and max_length to 65536. Writing frame_mode restarts
// parsing at a header; write registers only while the block is idle.
//
// When the receiver holds tx.ready low, the result waits in the output
// register while the queue keeps taking bytes; rx.ready falls once the queue
// holds four bytes.
// ----------------------------------------------------------------------------
module message_deframer_unit (
  input  logic                            clk,
  input  logic                            rst,
  mdf_in_if.sink                          rx,
  mdf_out_if.source                       tx,
  input  logic                            cfg_we,
  input  logic [mdf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mdf_pkg::REG_W-1:0]       cfg_data
);
  import mdf_pkg::*;

  cfg_t   cfg;
  logic   clear;
  entry_t push_data;
  logic   push_valid;
  logic   push_ready;
  entry_t pop_data;
  logic   pop_valid;
  logic   pop;

  // A write of frame_mode also restarts the parser.
  assign clear = cfg_we && (cfg_index == REG_FRAME_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_mode <= MODE_RAW;
      cfg.max_length <= MAX_LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_MODE: cfg.frame_mode <= cfg_data[MODE_W-1:0];
        REG_MAX_LENGTH: cfg.max_length <= cfg_data;
        default: ;
      endcase
    end
  end

  mdf_front u_front (
    .rx         (rx),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  mdf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid),
    .pop        (pop)
  );

  mdf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .clear     (clear),
    .pop_data  (pop_data),
    .pop_valid (pop_valid),
    .pop       (pop),
    .tx        (tx)
  );

endmodule

### hdl/mdf_front.sv
// ----------------------------------------------------------------------------
// Message deframer front end
// Accepts received bytes and tags them with their character classes.
// ----------------------------------------------------------------------------
module mdf_front (
  mdf_in_if.sink           rx,
  output mdf_pkg::entry_t  push_data,
  output logic             push_valid,
  input  logic             push_ready
);
  import mdf_pkg::*;

  assign rx.ready   = push_ready;
  assign push_valid = rx.valid;

  always_comb begin
    push_data           = '0;
    push_data.rx_byte   = rx.rx_byte;
    push_data.burst_end = rx.burst_end;
    push_data.is_cr     = (rx.rx_byte == CHAR_CR);
    push_data.is_lf     = (rx.rx_byte == CHAR_LF);
    push_data.is_digit  = (rx.rx_byte >= CHAR_0) && (rx.rx_byte <= CHAR_9);
    push_data.digit     = 4'(rx.rx_byte - CHAR_0);
    // Compare against every character of the field name at once, so the
    // parser only has to select the bit at its match position.
    for (int i = 0; i < NAME_LEN; i++) begin
      push_data.name_hit[i] = (rx.rx_byte == name_char(i));
    end
  end

endmodule

### hdl/mdf_queue.sv
// ----------------------------------------------------------------------------
// Message deframer queue
// Short first-in first-out buffer between the front end and the parser.
// ----------------------------------------------------------------------------
module mdf_queue (
  input  logic             clk,
  input  logic             rst,
  input  mdf_pkg::entry_t  push_data,
  input  logic             push_valid,
  output logic             push_ready,
  output mdf_pkg::entry_t  pop_data,
  output logic             pop_valid,
  input  logic             pop
);
  import mdf_pkg::*;

  entry_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

### hdl/mdf_back.sv
// ----------------------------------------------------------------------------
// Message deframer parser
// Runs the framing state machine on queued bytes and holds the result register.
// ----------------------------------------------------------------------------
module mdf_back (
  input  logic             clk,
  input  logic             rst,
  input  mdf_pkg::cfg_t    cfg,
  input  logic             clear,
  input  mdf_pkg::entry_t  pop_data,
  input  logic             pop_valid,
  output logic             pop,
  mdf_out_if.source        tx
);
  import mdf_pkg::*;

  localparam logic [1:0] PH_HEAD = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_DROP = 2'd2;

  logic [1:0]       phase,         phase_next;
  logic [PC_W-1:0]  prefix_count,  prefix_count_next;
  logic [ACC_W-1:0] length_accum,  length_accum_next;
  logic [LEN_W-1:0] bytes_left,    bytes_left_next;
  logic [1:0]       delim,         delim_next;
  logic [IDX_W-1:0] match_idx,     match_idx_next;
  logic             field_found,   field_found_next;
  logic             digits_active, digits_active_next;
  logic [LEN_W-1:0] body_length,   body_length_next;

  logic    out_valid;
  result_t out_reg;
  result_t res;
  logic    res_has;
  logic    step;
  logic    framed;

  assign framed = (cfg.frame_mode == MODE_PREFIX) || (cfg.frame_mode == MODE_HTTP);
  assign step   = pop_valid && (!out_valid || tx.ready);
  assign pop    = step;

  always_comb begin
    logic [LEN_W-1:0] dec;
    logic [LEN_W-1:0] len;
    logic [REG_W-1:0] len32;
    logic [ACC_W-1:0] acc_new;
    logic [IDX_W:0]   idx_new;
    logic [LEN_W+3:0] prod;
    logic [LEN_W+3:0] wide;

    phase_next         = phase;
    prefix_count_next  = prefix_count;
    length_accum_next  = length_accum;
    bytes_left_next    = bytes_left;
    delim_next         = delim;
    match_idx_next     = match_idx;
    field_found_next   = field_found;
    digits_active_next = digits_active;
    body_length_next   = body_length;
    res                = '0;
    res_has            = 1'b0;

    dec     = (bytes_left != '0) ? bytes_left - 1'b1 : bytes_left;
    acc_new = length_accum | (ACC_W'(pop_data.rx_byte) << (8 * prefix_count));
    len     = '0;
    len32   = '0;
    idx_new = '0;
    wide    = {4'b0, body_length};
    prod    = (wide << 3) + (wide << 1) + (LEN_W + 4)'(pop_data.digit);

    if (!framed) begin
      res_has      = 1'b1;
      res.msg_byte = pop_data.rx_byte;
      res.msg_last = pop_data.burst_end;
    end else if (phase == PH_DROP) begin
      bytes_left_next = dec;
      if (dec == '0) begin
        phase_next = PH_HEAD;
      end
    end else if (phase == PH_DATA) begin
      res_has         = 1'b1;
      res.msg_byte    = pop_data.rx_byte;
      res.is_body     = (cfg.frame_mode == MODE_HTTP);
      bytes_left_next = dec;
      if (dec == '0) begin
        res.msg_last = 1'b1;
        phase_next   = PH_HEAD;
      end
    end else if (cfg.frame_mode == MODE_PREFIX) begin
      if (({1'b0, prefix_count} + 3'd1) < 3'(PREFIX_BYTES)) begin
        prefix_count_next = prefix_count + 1'b1;
        length_accum_next = acc_new;
      end else begin
        len               = LEN_W'(acc_new);
        len32             = REG_W'(len);
        prefix_count_next = '0;
        length_accum_next = '0;
        if (len32 > cfg.max_length) begin
          phase_next       = PH_DROP;
          bytes_left_next  = len;
          res_has          = 1'b1;
          res.msg_last     = 1'b1;
          res.length_error = 1'b1;
        end else if (len == '0) begin
          res_has           = 1'b1;
          res.msg_last      = 1'b1;
          res.empty_message = 1'b1;
        end else begin
          phase_next      = PH_DATA;
          bytes_left_next = len;
        end
      end
    end else if (pop_data.is_lf && (delim == 2'd3)) begin
      // End of the header: start the body, close the message or drop an oversized body.
      len                = field_found ? body_length : '0;
      len32              = REG_W'(len);
      delim_next         = '0;
      match_idx_next     = '0;
      field_found_next   = 1'b0;
      digits_active_next = 1'b0;
      body_length_next   = '0;
      res_has            = 1'b1;
      if (len32 > cfg.max_length) begin
        phase_next       = PH_DROP;
        bytes_left_next  = len;
        res.msg_last     = 1'b1;
        res.length_error = 1'b1;
      end else if (len == '0) begin
        res.msg_byte = pop_data.rx_byte;
        res.msg_last = 1'b1;
      end else begin
        phase_next      = PH_DATA;
        bytes_left_next = len;
        res.msg_byte    = pop_data.rx_byte;
      end
    end else begin
      res_has      = 1'b1;
      res.msg_byte = pop_data.rx_byte;
      if (pop_data.is_cr) begin
        delim_next = (delim == 2'd2) ? 2'd3 : 2'd1;
      end else if (pop_data.is_lf && (delim == 2'd1)) begin
        delim_next = 2'd2;
      end else begin
        delim_next = 2'd0;
      end
      if (field_found) begin
        if (digits_active) begin
          if (pop_data.is_digit) begin
            body_length_next = (prod[LEN_W+3:LEN_W] != '0) ? '1 : prod[LEN_W-1:0];
          end else begin
            digits_active_next = 1'b0;
          end
        end
      end else begin
        if (pop_data.name_hit[match_idx]) begin
          idx_new = {1'b0, match_idx} + 1'b1;
        end else begin
          idx_new = pop_data.name_hit[0] ? (IDX_W + 1)'(1) : '0;
        end
        if (idx_new == (IDX_W + 1)'(NAME_LEN)) begin
          field_found_next   = 1'b1;
          digits_active_next = 1'b1;
          body_length_next   = '0;
          match_idx_next     = '0;
        end else begin
          match_idx_next = IDX_W'(idx_new);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      phase         <= PH_HEAD;
      prefix_count  <= '0;
      length_accum  <= '0;
      bytes_left    <= '0;
      delim         <= '0;
      match_idx     <= '0;
      field_found   <= 1'b0;
      digits_active <= 1'b0;
      body_length   <= '0;
    end else if (step) begin
      phase         <= phase_next;
      prefix_count  <= prefix_count_next;
      length_accum  <= length_accum_next;
      bytes_left    <= bytes_left_next;
      delim         <= delim_next;
      match_idx     <= match_idx_next;
      field_found   <= field_found_next;
      digits_active <= digits_active_next;
      body_length   <= body_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res_has) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_has) begin
      out_reg <= res;
    end
  end

  assign tx.valid         = out_valid;
  assign tx.msg_byte      = out_reg.msg_byte;
  assign tx.msg_last      = out_reg.msg_last;
  assign tx.empty_message = out_reg.empty_message;
  assign tx.length_error  = out_reg.length_error;
  assign tx.is_body       = out_reg.is_body;

  a_error_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_reg.length_error |-> out_reg.msg_last && (out_reg.msg_byte == '0))
    else $error("length error marker without last flag or with data");

  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_reg.empty_message |-> out_reg.msg_last && !out_reg.length_error)
    else $error("empty message marker malformed");

  a_body_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_reg.is_body |-> cfg.frame_mode == MODE_HTTP)
    else $error("body byte outside HTTP mode");

  a_count_live: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) || (phase == PH_DROP) |-> bytes_left != '0)
    else $error("payload phase with no bytes left");

endmodule

### tb/sv/mdf_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message deframer checker
// Tracks the framing state of the byte stream and checks every result.
// ----------------------------------------------------------------------------
package mdf_tb_pkg;
  import mdf_pkg::*;

  typedef enum int {AT_HEADER, IN_DATA, DROPPING} parse_phase_e;
  typedef enum int {DL_NONE, DL_CR, DL_CRLF, DL_CRLFCR} delim_e;

  class deframe_checker;
    result_t          pending_results[$];
    int unsigned      failures;
    string            field_text = "Content-Length: ";

    logic [MODE_W-1:0] mode;
    logic [REG_W-1:0]  max_len;
    parse_phase_e      phase;
    int                prefix_cnt;
    logic [LEN_W-1:0]  len_acc;
    logic [LEN_W-1:0]  left;
    logic [LEN_W-1:0]  body_len;
    delim_e            delim;
    int                match_idx;
    bit                found;
    bit                digits_on;

    function new();
      failures = 0;
      mode     = MODE_RAW;
      max_len  = MAX_LENGTH_RESET;
      clear_parse();
    endfunction

    function void clear_parse();
      phase      = AT_HEADER;
      prefix_cnt = 0;
      len_acc    = '0;
      left       = '0;
      body_len   = '0;
      delim      = DL_NONE;
      match_idx  = 0;
      found      = 0;
      digits_on  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
      if (idx == REG_FRAME_MODE) begin
        mode = data[MODE_W-1:0];
        clear_parse();
      end else if (idx == REG_MAX_LENGTH) begin
        max_len = data;
      end
    endfunction

    // Watches the header for the length field and accumulates its digits.
    function void scan_header(logic [BYTE_W-1:0] b);
      logic [LEN_W+3:0] grown;
      if (found) begin
        if (digits_on) begin
          if (b >= CHAR_0 && b <= CHAR_9) begin
            grown    = {4'b0, body_len} * 10 + (b - CHAR_0);
            body_len = (grown > {4'b0, {LEN_W{1'b1}}}) ? '1 : grown[LEN_W-1:0];
          end else begin
            digits_on = 0;
          end
        end
        return;
      end
      if (match_idx < NAME_LEN && b == field_text[match_idx]) match_idx++;
      else match_idx = (b == field_text[0]) ? 1 : 0;
      if (match_idx >= NAME_LEN) begin
        found     = 1;
        digits_on = 1;
        body_len  = '0;
        match_idx = 0;
      end
    endfunction

    function bit take_prefix(logic [BYTE_W-1:0] b, inout result_t r);
      logic [LEN_W-1:0] len;
      len_acc[8*prefix_cnt +: 8] = b;
      if (prefix_cnt + 1 < PREFIX_BYTES) begin
        prefix_cnt++;
        return 0;
      end
      len = len_acc;
      clear_parse();
      if (len > max_len) begin
        phase          = DROPPING;
        left           = len;
        r.msg_last     = 1;
        r.length_error = 1;
        return 1;
      end
      if (len == 0) begin
        r.msg_last      = 1;
        r.empty_message = 1;
        return 1;
      end
      phase = IN_DATA;
      left  = len;
      return 0;
    endfunction

    function bit take_http(logic [BYTE_W-1:0] b, inout result_t r);
      logic [LEN_W-1:0] len;
      if (b == CHAR_LF && delim == DL_CRLFCR) begin
        len = found ? body_len : '0;
        clear_parse();
        if (len > max_len) begin
          phase          = DROPPING;
          left           = len;
          r.msg_last     = 1;
          r.length_error = 1;
          return 1;
        end
        r.msg_byte = b;
        if (len == 0) begin
          r.msg_last = 1;
        end else begin
          phase = IN_DATA;
          left  = len;
        end
        return 1;
      end
      if (b == CHAR_CR) delim = (delim == DL_CRLF) ? DL_CRLFCR : DL_CR;
      else if (b == CHAR_LF && delim == DL_CR) delim = DL_CRLF;
      else delim = DL_NONE;
      scan_header(b);
      r.msg_byte = b;
      return 1;
    endfunction

    // Returns 1 when the byte produces a result, which is left in r.
    function bit frame_byte(logic [BYTE_W-1:0] b, logic e, output result_t r);
      r = '0;
      if (mode != MODE_PREFIX && mode != MODE_HTTP) begin
        r.msg_byte = b;
        r.msg_last = e;
        return 1;
      end
      if (phase == DROPPING) begin
        if (left != 0) left--;
        if (left == 0) clear_parse();
        return 0;
      end
      if (phase == IN_DATA) begin
        if (left != 0) left--;
        r.msg_byte = b;
        r.is_body  = (mode == MODE_HTTP);
        if (left == 0) begin
          clear_parse();
          r.msg_last = 1;
        end
        return 1;
      end
      if (mode == MODE_PREFIX) return take_prefix(b, r);
      return take_http(b, r);
    endfunction

    function void note_input(logic [BYTE_W-1:0] b, logic e);
      result_t r;
      if (frame_byte(b, e, r)) pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %02h/%b/%b/%b/%b",
                 $time, got.msg_byte, got.msg_last, got.empty_message,
                 got.length_error, got.is_body);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("msg_byte", want.msg_byte, got.msg_byte);
      compare_field("msg_last", want.msg_last, got.msg_last);
      compare_field("empty_message", want.empty_message, got.empty_message);
      compare_field("length_error", want.length_error, got.length_error);
      compare_field("is_body", want.is_body, got.is_body);
    endfunction

    function void report_leftover();
      if (pending_results.size() != 0) begin
        $display("%0t: %0d results expected, actual none", $time, pending_results.size());
        failures += pending_results.size();
      end
    endfunction
  endclass

endpackage

### tb/sv/tb_message_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message deframer testbench
// Streams bytes through all framing modes and checks every result transaction
// against a cycle-free model of the deframer held in a checker object.
// ----------------------------------------------------------------------------
module tb_message_deframer_unit;
  import mdf_pkg::*;
  import mdf_tb_pkg::*;

  // The fourth mode code is unused and must behave like raw passthrough.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int N_PHASES     = 9;
  localparam int PHASE_ITEMS  = 125;
  localparam int IDLE_PCT     = 7;
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = 8;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int CYCLE_LIMIT  = 200000;

  localparam string CRLF = "\015\012";

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data  = '0;

  mdf_in_if  rx_ch ();
  mdf_out_if tx_ch ();

  deframe_checker chk;

  // Random phase table: framing mode, length limit and whether the receiver
  // stalls for a long stretch at the start of the phase.
  logic [MODE_W-1:0] run_mode [N_PHASES] = '{MODE_RAW, MODE_PREFIX, MODE_HTTP, MODE_PREFIX,
                                             MODE_HTTP, MODE_UNUSED, MODE_HTTP, MODE_PREFIX,
                                             MODE_HTTP};
  logic [REG_W-1:0]  run_max  [N_PHASES] = '{32'd65536, 32'd0, 32'hFFFF_FFFF, 32'd8, 32'd5,
                                             32'd17, 32'd0, 32'hFFFF_FFFF, 32'd65536};
  bit                run_hold [N_PHASES] = '{1, 0, 0, 0, 0, 0, 0, 1, 0};

  bit               rx_may_idle = 1'b1;
  bit               tx_may_idle = 1'b1;
  int               hold_asks   = 0;
  int               items_sent  = 0;
  int unsigned      cycle_count = 0;
  logic [REG_W-1:0] limit_now   = MAX_LENGTH_RESET;
  logic [BYTE_W-1:0] frame_buf[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  message_deframer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .tx        (tx_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Hard stop in case the block deadlocks or loses results.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Every result transaction is checked against the oldest expectation. The
  // fields are packed in the same order as result_t.
  always @(posedge clk) begin : check_tx
    result_t got;
    if (!rst && tx_ch.valid && tx_ch.ready) begin
      got = {tx_ch.msg_byte, tx_ch.msg_last, tx_ch.empty_message,
             tx_ch.length_error, tx_ch.is_body};
      chk.check_result(got);
    end
  end

  // Receiver. It drops ready at random while idling is allowed, and on each
  // request from the stimulus it holds ready low for a long counted stretch so
  // that the internal queue fills and the block stalls its input.
  initial begin : tx_sink
    int served;
    int hold_left;
    served    = 0;
    hold_left = 0;
    tx_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (served < hold_asks) begin
        served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        tx_ch.ready = 1'b0;
      end else begin
        tx_ch.ready = !(tx_may_idle && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Offers one byte, starting just after a falling edge, and returns just
  // after the falling edge that follows the accepting rising edge. Valid stays
  // high between back-to-back bytes.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic e);
    while (rx_may_idle && $urandom_range(99) < IDLE_PCT) begin
      rx_ch.valid = 1'b0;
      @(negedge clk);
    end
    rx_ch.valid     = 1'b1;
    rx_ch.rx_byte   = b;
    rx_ch.burst_end = e;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    chk.note_input(b, e);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic push_text(input string s);
    foreach (s[i]) frame_buf.push_back(s[i]);
  endtask

  // Queues a length header, low byte first. Zero bytes cannot travel in a
  // string, so headers are built from a number.
  task automatic push_word(input logic [LEN_W-1:0] w);
    for (int i = 0; i < PREFIX_BYTES; i++) frame_buf.push_back(w[8*i +: 8]);
  endtask

  // Sends the buffered bytes. The last one carries the given burst flag, the
  // others a random one that occasionally closes a raw message early.
  task automatic flush_frame(input bit end_last);
    int n;
    n = frame_buf.size();
    for (int i = 0; i < n; i++)
      send_byte(frame_buf[i], (i == n - 1) ? end_last : ($urandom_range(7) == 0));
    frame_buf.delete();
  endtask

  task automatic send_text(input string s);
    push_text(s);
    flush_frame(1'($urandom_range(1)));
  endtask

  // Lets the block drain: no transaction offered, every expected result seen,
  // then a further drain wait for bytes that were consumed without a result.
  task automatic wait_idle();
    int waited;
    rx_ch.valid = 1'b0;
    waited = 0;
    while (chk.pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    chk.write_reg(idx, data);
    if (idx == REG_MAX_LENGTH) limit_now = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(input logic [MODE_W-1:0] mode, input logic [REG_W-1:0] max_len);
    wait_idle();
    write_reg(REG_MAX_LENGTH, max_len);
    write_reg(REG_FRAME_MODE, mode);
  endtask

  // Declared lengths stay small so that dropped messages end quickly. When
  // the limit is small, about a quarter of the lengths exceed it.
  function automatic logic [LEN_W-1:0] pick_length();
    if (limit_now < 24 && $urandom_range(99) < 25)
      return limit_now + 1 + $urandom_range(0, 6);
    return $urandom_range(0, (limit_now < 12) ? limit_now : 12);
  endfunction

  task automatic gen_raw();
    repeat ($urandom_range(1, 8)) frame_buf.push_back(BYTE_W'($urandom_range(0, 255)));
    flush_frame(1'b1);
  endtask

  task automatic gen_prefix();
    logic [LEN_W-1:0] len;
    len = pick_length();
    for (int i = 0; i < PREFIX_BYTES; i++) frame_buf.push_back(len[8*i +: 8]);
    repeat (len) frame_buf.push_back(BYTE_W'($urandom_range(0, 255)));
    flush_frame(1'($urandom_range(1)));
  endtask

  // An HTTP message: a request line, a few header lines with the length field
  // in any position (the last one included), an occasional later duplicate of
  // the field that must be ignored, the blank line, and the body. A few
  // messages are plain noise that leaves the parser in the middle of a header.
  task automatic gen_http();
    logic [LEN_W-1:0] len;
    bit    with_len;
    int    n_lines;
    int    len_at;
    string pre;
    string zeros;
    string tail;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 10)) frame_buf.push_back(BYTE_W'($urandom_range(0, 255)));
      flush_frame(1'($urandom_range(1)));
      return;
    end
    with_len = ($urandom_range(99) < 80);
    len      = with_len ? pick_length() : '0;
    n_lines  = $urandom_range(0, 2);
    len_at   = $urandom_range(0, n_lines);
    push_text({"GET /", CRLF});
    for (int i = 0; i <= n_lines; i++) begin
      if (with_len && i == len_at) begin
        case ($urandom_range(0, 2))
          0:       pre = "";
          1:       pre = "X-";
          default: pre = "C";
        endcase
        zeros = ($urandom_range(0, 3) == 0) ? "00" : "";
        case ($urandom_range(0, 2))
          0:       tail = "";
          1:       tail = " ";
          default: tail = ";q";
        endcase
        push_text({pre, "Content-Length: ", zeros, $sformatf("%0d", len), tail, CRLF});
      end else begin
        case ($urandom_range(0, 3))
          0: push_text({"Host: h", CRLF});
          1: push_text({"content-length: 9", CRLF});
          2: push_text({"Content-Len: 5", CRLF});
          default: begin
            repeat ($urandom_range(0, 5)) frame_buf.push_back(BYTE_W'($urandom_range(0, 255)));
            push_text(CRLF);
          end
        endcase
      end
    end
    if (with_len && $urandom_range(99) < 20) push_text({"Content-Length: 77", CRLF});
    push_text(CRLF);
    repeat (len) frame_buf.push_back(BYTE_W'($urandom_range(0, 255)));
    flush_frame(1'($urandom_range(1)));
  endtask

  initial begin : stimulus
    int start;

    chk = new();
    rx_ch.valid     = 1'b0;
    rx_ch.rx_byte   = '0;
    rx_ch.burst_end = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Raw mode out of reset: extreme byte values, with and without burst end.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h5A, 1'b1);

    // Length prefix with a zero limit: an empty message gives its marker, any
    // other length is an error and its payload is dropped.
    configure(MODE_PREFIX, 32'd0);
    push_word(32'd0);
    flush_frame(1'($urandom_range(1)));
    push_word(32'd2);
    send_text("\252\125");

    // Largest limit: a normal one-byte message, then the largest declared
    // length, which is cut off by the next mode write.
    configure(MODE_PREFIX, 32'hFFFF_FFFF);
    push_word(32'd1);
    send_text("\176");
    send_text("\377\377\377\377\061\062\063");

    // HTTP: a bare delimiter, the length field on the last header line, and a
    // value too large for 32 bits that saturates; that body is cut off too.
    configure(MODE_HTTP, 32'hFFFF_FFFF);
    send_text({CRLF, CRLF});
    send_text({"Content-Length: 2", CRLF, CRLF, "ab"});
    send_text({"Content-Length: 99999999999", CRLF, CRLF, "zz"});

    // A body longer than the limit is flagged and dropped; a field with no
    // digits means an empty body.
    configure(MODE_HTTP, 32'd3);
    send_text({"A: 1", CRLF, "Content-Length: 4", CRLF, CRLF, "wxyz"});
    send_text({"Content-Length: x", CRLF, CRLF});

    // Random phases. Phase 3 runs with no idling on either side, and two
    // phases open with a long receiver stall while the sender keeps going.
    run_max[6] = $urandom_range(0, 20);
    for (int p = 0; p < N_PHASES; p++) begin
      configure(run_mode[p], run_max[p]);
      rx_may_idle = (p != 3);
      tx_may_idle = (p != 3);
      if (run_hold[p]) hold_asks++;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        case (run_mode[p])
          MODE_PREFIX: gen_prefix();
          MODE_HTTP:   gen_http();
          default:     gen_raw();
        endcase
      end
    end

    wait_idle();
    chk.report_leftover();
    if (chk.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
hdl/mdf_pkg.sv
hdl/mdf_if.sv
hdl/mdf_front.sv
hdl/mdf_queue.sv
hdl/mdf_back.sv
hdl/message_deframer_unit.sv
tb/sv/mdf_tb_pkg.sv
tb/sv/tb_message_deframer_unit.sv
